FILE: src/atht_pkg.sv
package atht_pkg;

  localparam int TableDepth = 4096;
  localparam int SlotW = $clog2(TableDepth);
  localparam int CountW = SlotW + 1;
  localparam logic [63:0] HashMult = 64'h9E3779B97F4A7C15;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [CountW+1:0] FullLimit = (CountW+2)'(TableDepth * 3);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ZERO    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_HOME,
    S_READ,
    S_WAIT,
    S_PROBE,
    S_REIN_HASH,
    S_REIN_HOME,
    S_REIN_READ,
    S_REIN_WAIT,
    S_REIN_PROBE,
    S_CLEAR,
    S_FINISH
  } state_t;

  // controller commands to datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic hash_mul;    // register hash product
    logic set_home;    // probe pointer <- home of key
    logic step;        // probe pointer + 1
    logic wr_item;     // write key/size at probe pointer
    logic wr_empty;    // clear slot at probe pointer
    logic set_scan;    // scan pointer <- probe pointer + 1, remember released
    logic rd_scan;     // read at scan pointer
    logic pick_scan;   // take scanned entry as key to move, clear its slot
    logic sel_moved;   // hash or write the moved entry instead of the input beat
    logic clr_step;    // clearing sweep write
    logic clr_start;   // reset sweep pointer and stats
    logic stat_alloc;
    logic stat_release;
    logic stat_unknown;
    logic set_status;
    status_t status;
    logic fire;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic addr_zero;
    logic full;
    logic slot_empty;
    logic slot_match;
    logic clr_last;
  } sts_t;

endpackage

FILE: src/atht_ctrl.sv
module atht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  atht_pkg::sts_t  sts,
  output atht_pkg::cmd_t  cmd
);

  atht_pkg::state_t state_r, state_nxt;
  logic clr_pend_r, clr_pend_nxt;
  logic mov_r, mov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atht_pkg::S_CLEAR;
      clr_pend_r <= 1'b1;
      mov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_pend_r <= clr_pend_nxt;
      mov_r <= mov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_pend_nxt = clr_pend_r;
    mov_nxt = mov_r;
    cmd = '0;
    cmd.status = atht_pkg::ST_DONE;
    busy = (state_r != atht_pkg::S_IDLE);
    unique case (state_r)
      atht_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          mov_nxt = 1'b0;
          state_nxt = atht_pkg::S_HASH;
        end
      end
      atht_pkg::S_HASH: begin
        cmd.hash_mul = 1'b1;
        state_nxt = atht_pkg::S_HOME;
        unique case (sts.op)
          atht_pkg::OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            clr_pend_nxt = 1'b0;
            state_nxt = atht_pkg::S_CLEAR;
          end
          atht_pkg::OP_NONE: begin
            cmd.set_status = 1'b1;
            state_nxt = atht_pkg::S_FINISH;
          end
          default: begin
            if (sts.addr_zero) begin
              cmd.set_status = 1'b1;
              cmd.status = atht_pkg::ST_ZERO;
              state_nxt = atht_pkg::S_FINISH;
            end else if (sts.op == atht_pkg::OP_ALLOC && sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status = atht_pkg::ST_FULL;
              state_nxt = atht_pkg::S_FINISH;
            end
          end
        endcase
      end
      atht_pkg::S_HOME: begin
        cmd.set_home = 1'b1;
        state_nxt = atht_pkg::S_READ;
      end
      atht_pkg::S_READ: begin
        state_nxt = atht_pkg::S_WAIT;
      end
      atht_pkg::S_WAIT: state_nxt = atht_pkg::S_PROBE;
      atht_pkg::S_PROBE: begin
        if (mov_r) begin
          // moved entry lands in the first empty slot, then the scan resumes
          if (sts.slot_empty) begin
            cmd.wr_item = 1'b1;
            cmd.sel_moved = 1'b1;
            state_nxt = atht_pkg::S_REIN_READ;
          end else begin
            cmd.step = 1'b1;
            state_nxt = atht_pkg::S_READ;
          end
        end else if (sts.op == atht_pkg::OP_ALLOC) begin
          if (sts.slot_empty) begin
            cmd.wr_item = 1'b1;
            cmd.stat_alloc = 1'b1;
            cmd.set_status = 1'b1;
            state_nxt = atht_pkg::S_FINISH;
          end else begin
            cmd.step = 1'b1;
            state_nxt = atht_pkg::S_READ;
          end
        end else if (sts.slot_empty) begin
          cmd.stat_unknown = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = atht_pkg::ST_UNKNOWN;
          state_nxt = atht_pkg::S_FINISH;
        end else if (sts.slot_match) begin
          cmd.wr_empty = 1'b1;
          cmd.set_scan = 1'b1;
          cmd.stat_release = 1'b1;
          cmd.set_status = 1'b1;
          state_nxt = atht_pkg::S_REIN_READ;
        end else begin
          cmd.step = 1'b1;
          state_nxt = atht_pkg::S_READ;
        end
      end
      atht_pkg::S_REIN_READ: begin
        cmd.rd_scan = 1'b1;
        state_nxt = atht_pkg::S_REIN_WAIT;
      end
      atht_pkg::S_REIN_WAIT: begin
        cmd.rd_scan = 1'b1;
        state_nxt = atht_pkg::S_REIN_HASH;
      end
      atht_pkg::S_REIN_HASH: begin
        if (sts.slot_empty) begin
          state_nxt = atht_pkg::S_FINISH;
        end else begin
          cmd.pick_scan = 1'b1;
          cmd.sel_moved = 1'b1;
          mov_nxt = 1'b1;
          state_nxt = atht_pkg::S_REIN_HOME;
        end
      end
      atht_pkg::S_REIN_HOME: begin
        cmd.sel_moved = 1'b1;
        cmd.hash_mul = 1'b1;
        state_nxt = atht_pkg::S_REIN_PROBE;
      end
      atht_pkg::S_REIN_PROBE: begin
        // reuse the read/wait/decide walk for the moved entry
        cmd.set_home = 1'b1;
        cmd.sel_moved = 1'b1;
        state_nxt = atht_pkg::S_READ;
      end
      atht_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (clr_pend_r) begin
            clr_pend_nxt = 1'b0;
            state_nxt = atht_pkg::S_IDLE;
          end else begin
            cmd.set_status = 1'b1;
            state_nxt = atht_pkg::S_FINISH;
          end
        end
      end
      atht_pkg::S_FINISH: begin
        cmd.fire = 1'b1;
        mov_nxt = 1'b0;
        state_nxt = atht_pkg::S_IDLE;
      end
      default: state_nxt = atht_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/atht_dp.sv
module atht_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_opcode,
  input  logic [63:0]     in_address,
  input  logic [31:0]     in_size,
  input  atht_pkg::cmd_t  cmd,
  output atht_pkg::sts_t  sts,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [31:0]     out_released_size,
  output logic [47:0]     out_live_bytes,
  output logic [47:0]     out_peak_bytes,
  output logic [47:0]     out_total_bytes,
  output logic [31:0]     out_alloc_count,
  output logic [31:0]     out_unknown_count
);

  localparam int SW = atht_pkg::SlotW;
  localparam int CW = atht_pkg::CountW;

  logic [63:0] key_mem [atht_pkg::TableDepth];
  logic [31:0] size_mem [atht_pkg::TableDepth];

  logic [1:0]  op_r;
  logic [63:0] addr_r, mkey_r, rkey_r;
  logic [31:0] size_r, msize_r, rsize_r, rel_r;
  logic [SW-1:0] prod_r, ptr_r, scan_r, clr_r;
  logic [CW-1:0] used_r;
  logic [47:0] live_r, peak_r, total_r;
  logic [31:0] acnt_r, ucnt_r;
  logic [1:0]  status_r;
  logic        valid_r;

  logic [63:0] hkey;
  logic [48:0] live_add, total_add;
  logic [47:0] live_new;
  logic        wen;
  logic [SW-1:0] waddr;
  logic [63:0] wkey;
  logic [31:0] wsize;
  logic [SW-1:0] raddr;

  assign hkey = cmd.sel_moved ? mkey_r : addr_r;

  // write port mux
  always_comb begin
    wen = 1'b0;
    waddr = ptr_r;
    wkey = '0;
    wsize = '0;
    if (cmd.clr_step) begin
      wen = 1'b1;
      waddr = clr_r;
    end else if (cmd.wr_item) begin
      wen = 1'b1;
      wkey = cmd.sel_moved ? mkey_r : addr_r;
      wsize = cmd.sel_moved ? msize_r : size_r;
    end else if (cmd.wr_empty) begin
      wen = 1'b1;
    end else if (cmd.pick_scan) begin
      wen = 1'b1;
      waddr = scan_r;
    end
  end

  assign raddr = cmd.rd_scan ? scan_r : ptr_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      key_mem[waddr] <= wkey;
      size_mem[waddr] <= wsize;
    end
    rkey_r <= key_mem[raddr];
    rsize_r <= size_mem[raddr];
  end

  assign live_add = {1'b0, live_r} + {17'd0, size_r};
  assign total_add = {1'b0, total_r} + {17'd0, size_r};
  assign live_new = live_add[48] ? atht_pkg::Max48 : live_add[47:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      addr_r <= in_address;
      size_r <= in_size;
      rel_r <= '0;
    end
    // only the low slot bits of the product are kept, so only low operand bits matter
    if (cmd.hash_mul) prod_r <= SW'(hkey[SW+3:4] * atht_pkg::HashMult[SW-1:0]);
    if (cmd.set_home) ptr_r <= prod_r;
    else if (cmd.step) ptr_r <= ptr_r + 1'b1;
    if (cmd.set_scan) begin
      scan_r <= ptr_r + 1'b1;
      rel_r <= rsize_r;
    end else if (cmd.pick_scan) begin
      mkey_r <= rkey_r;
      msize_r <= rsize_r;
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.set_status) status_r <= cmd.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      used_r <= '0;
      live_r <= '0;
      peak_r <= '0;
      total_r <= '0;
      acnt_r <= '0;
      ucnt_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.fire;
      if (cmd.clr_start) begin
        clr_r <= '0;
        used_r <= '0;
        live_r <= '0;
        peak_r <= '0;
        total_r <= '0;
        acnt_r <= '0;
        ucnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.stat_alloc) begin
        used_r <= used_r + 1'b1;
        live_r <= live_new;
        total_r <= total_add[48] ? atht_pkg::Max48 : total_add[47:0];
        if (acnt_r != atht_pkg::Max32) acnt_r <= acnt_r + 1'b1;
        if (live_new > peak_r) peak_r <= live_new;
      end
      if (cmd.stat_release) begin
        used_r <= used_r - 1'b1;
        live_r <= (live_r >= {16'd0, rsize_r}) ? live_r - {16'd0, rsize_r} : '0;
      end
      if (cmd.stat_unknown && ucnt_r != atht_pkg::Max32) ucnt_r <= ucnt_r + 1'b1;
    end
  end

  assign sts.op = atht_pkg::op_t'(op_r);
  assign sts.addr_zero = (addr_r == '0);
  assign sts.full = ({used_r, 2'b00} >= atht_pkg::FullLimit);
  assign sts.slot_empty = (rkey_r == '0);
  assign sts.slot_match = (rkey_r == addr_r);
  assign sts.clr_last = (clr_r == {SW{1'b1}});

  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_released_size = rel_r;
  assign out_live_bytes = live_r;
  assign out_peak_bytes = peak_r;
  assign out_total_bytes = total_r;
  assign out_alloc_count = acnt_r;
  assign out_unknown_count = ucnt_r;

endmodule

FILE: src/allocation_tracking_hash_table.sv
// a zero address, unused op or full table finishes without probing; an allocate or a
//   release that misses walks each probed slot in turn
// a release that hits also pulls each entry behind it in the cluster and probes it back
//   in from its home slot; clear sweeps every slot
// throughput: one beat in flight, the next start is taken in the result cycle
// reset: sync active low, then a clearing sweep of every slot with busy high; no receiver stall
module allocation_tracking_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_address,
  input  logic [31:0] in_size,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_released_size,
  output logic [47:0] out_live_bytes,
  output logic [47:0] out_peak_bytes,
  output logic [47:0] out_total_bytes,
  output logic [31:0] out_alloc_count,
  output logic [31:0] out_unknown_count
);

  // controller walks probes and cluster reinsertion, datapath owns the slot memory
  atht_pkg::cmd_t cmd;
  atht_pkg::sts_t sts;

  atht_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  atht_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_size          (in_size),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_released_size(out_released_size),
    .out_live_bytes   (out_live_bytes),
    .out_peak_bytes   (out_peak_bytes),
    .out_total_bytes  (out_total_bytes),
    .out_alloc_count  (out_alloc_count),
    .out_unknown_count(out_unknown_count)
  );

  a_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result beat without work");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");

endmodule

FILE: tb/allocation_tracking_hash_table_tb.sv
module allocation_tracking_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one result beat as the block reports it
  typedef struct packed {
    atht_pkg::status_t status;
    logic [31:0]       released_size;
    logic [47:0]       live_bytes;
    logic [47:0]       peak_bytes;
    logic [47:0]       total_bytes;
    logic [31:0]       alloc_count;
    logic [31:0]       unknown_count;
  } stats_beat_t;

  // shadow allocation table: predicts the stats beat of every accepted command
  class alloc_scoreboard;
    bit [63:0]   keys [atht_pkg::TableDepth];
    bit [31:0]   sizes [atht_pkg::TableDepth];
    int          used;
    bit [47:0]   live, peak, sum;
    bit [31:0]   allocs, unknowns;
    stats_beat_t pending [$];
    int          errors;

    function bit [atht_pkg::SlotW-1:0] home_of(bit [63:0] a);
      bit [63:0] p;
      p = (a >> 4) * atht_pkg::HashMult;
      return p[atht_pkg::SlotW-1:0];
    endfunction

    function void insert(bit [63:0] a, bit [31:0] s);
      bit [atht_pkg::SlotW-1:0] i;
      int k;
      i = home_of(a);
      for (k = 0; k < atht_pkg::TableDepth && keys[i] != 0; k++) i = i + 1;
      if (keys[i] != 0) return;
      keys[i] = a;
      sizes[i] = s;
      used++;
    endfunction

    // drop first match, then pull the rest of the cluster and put it back
    function bit take_out(bit [63:0] a, output bit [31:0] s);
      bit [atht_pkg::SlotW-1:0] i, j;
      bit [63:0] q;
      bit [31:0] m;
      int k, r;
      s = 0;
      i = home_of(a);
      for (k = 0; k < atht_pkg::TableDepth && keys[i] != 0; k++) begin
        if (keys[i] == a) begin
          s = sizes[i];
          keys[i] = 0;
          sizes[i] = 0;
          used--;
          j = i + 1;
          for (r = 0; r < atht_pkg::TableDepth && keys[j] != 0; r++) begin
            q = keys[j];
            m = sizes[j];
            keys[j] = 0;
            sizes[j] = 0;
            used--;
            insert(q, m);
            j = j + 1;
          end
          return 1;
        end
        i = i + 1;
      end
      return 0;
    endfunction

    function bit [63:0] some_live();
      int s, k;
      s = $urandom_range(atht_pkg::TableDepth - 1);
      for (k = 0; k < atht_pkg::TableDepth; k++)
        if (keys[(s + k) % atht_pkg::TableDepth] != 0)
          return keys[(s + k) % atht_pkg::TableDepth];
      return 0;
    endfunction

    function void note_command(atht_pkg::op_t op, bit [63:0] a, bit [31:0] s);
      stats_beat_t e;
      bit [48:0] t;
      bit [31:0] got;
      e.status = atht_pkg::ST_DONE;
      e.released_size = 0;
      case (op)
        atht_pkg::OP_ALLOC: begin
          if (a == 0) e.status = atht_pkg::ST_ZERO;
          else if (used * 4 >= atht_pkg::TableDepth * 3) e.status = atht_pkg::ST_FULL;
          else begin
            insert(a, s);
            t = live + s;
            live = (t > atht_pkg::Max48) ? atht_pkg::Max48 : t[47:0];
            t = sum + s;
            sum = (t > atht_pkg::Max48) ? atht_pkg::Max48 : t[47:0];
            if (allocs != atht_pkg::Max32) allocs++;
            if (live > peak) peak = live;
          end
        end
        atht_pkg::OP_RELEASE: begin
          if (a == 0) e.status = atht_pkg::ST_ZERO;
          else if (take_out(a, got)) begin
            e.released_size = got;
            live = (live >= got) ? live - got : 0;
          end else begin
            e.status = atht_pkg::ST_UNKNOWN;
            if (unknowns != atht_pkg::Max32) unknowns++;
          end
        end
        atht_pkg::OP_CLEAR: begin
          foreach (keys[n]) begin
            keys[n] = 0;
            sizes[n] = 0;
          end
          used = 0;
          live = 0;
          peak = 0;
          sum = 0;
          allocs = 0;
          unknowns = 0;
        end
        default: ;
      endcase
      e.live_bytes = live;
      e.peak_bytes = peak;
      e.total_bytes = sum;
      e.alloc_count = allocs;
      e.unknown_count = unknowns;
      pending.push_back(e);
    endfunction

    function void check_beat(stats_beat_t got);
      stats_beat_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.released_size !== e.released_size ||
          got.live_bytes !== e.live_bytes || got.peak_bytes !== e.peak_bytes ||
          got.total_bytes !== e.total_bytes || got.alloc_count !== e.alloc_count ||
          got.unknown_count !== e.unknown_count) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [63:0] in_address;
  logic [31:0] in_size;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_released_size;
  logic [47:0] out_live_bytes;
  logic [47:0] out_peak_bytes;
  logic [47:0] out_total_bytes;
  logic [31:0] out_alloc_count;
  logic [31:0] out_unknown_count;

  allocation_tracking_hash_table u_dut (.*);

  alloc_scoreboard sb = new();

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  int        idle_pct;   // chance of a sender idle cycle before each beat
  int        stuck = 0;  // cycles with no beat moving either way
  bit [63:0] pool [32];  // small address set: duplicates, collisions, misses

  // result side: the receiver never stalls, every strobe is a beat
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_beat({atht_pkg::status_t'(out_status), out_released_size, out_live_bytes,
                     out_peak_bytes, out_total_bytes, out_alloc_count, out_unknown_count});
  end

  // watchdog: clear sweeps and long release clusters stay well under this
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one command beat at the falling edge and hold it until accepted
  task automatic send(atht_pkg::op_t op, bit [63:0] a, bit [31:0] s);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_address = a;
    in_size = s;
    do @(posedge clk); while (busy);
    sb.note_command(op, a, s);
  endtask

  function automatic bit [63:0] rand_addr();
    bit [63:0] a;
    a = {$urandom, $urandom};
    return (a == 0) ? 64'h10 : a;
  endfunction

  function automatic bit [31:0] rand_size();
    case ($urandom_range(3))
      0: return $urandom_range(255);
      1: return $urandom;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // random mix: mostly alloc/release pairs of live keys, some misses and noise
  task automatic random_burst(int n);
    int pick;
    bit [63:0] a;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 48) begin
        a = ($urandom_range(2) == 0) ? pool[$urandom_range(31)] : rand_addr();
        send(atht_pkg::OP_ALLOC, a, rand_size());
      end else if (pick < 83) begin
        send(atht_pkg::OP_RELEASE, sb.some_live(), $urandom);
      end else if (pick < 93) begin
        a = ($urandom_range(1) == 0) ? pool[$urandom_range(31)] : rand_addr();
        send(atht_pkg::OP_RELEASE, a, $urandom);
      end else if (pick < 97) begin
        send(atht_pkg::op_t'($urandom_range(1)), 64'd0, $urandom);
      end else if (pick < 99) begin
        send(atht_pkg::OP_NONE, rand_addr(), $urandom);
      end else begin
        send(atht_pkg::OP_CLEAR, rand_addr(), $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = atht_pkg::OP_ALLOC;
    in_address = '0;
    in_size = '0;
    idle_pct = 0;
    // half the pool shares address >> 4 with the other half: same home slot
    for (int n = 0; n < 16; n++) begin
      pool[n] = rand_addr() | 64'h100;
      pool[n + 16] = {pool[n][63:4], 4'(n)};
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: zero address, unused op, extremes, duplicates, cluster reinsert
    send(atht_pkg::OP_ALLOC, 64'd0, 32'd5);
    send(atht_pkg::OP_RELEASE, 64'd0, 32'd0);
    send(atht_pkg::OP_NONE, '1, '1);
    send(atht_pkg::OP_RELEASE, 64'h1234_5678, 32'd0);
    send(atht_pkg::OP_ALLOC, '1, '1);
    send(atht_pkg::OP_ALLOC, 64'd1, 32'd0);
    send(atht_pkg::OP_ALLOC, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send(atht_pkg::OP_ALLOC, pool[0], 32'd100);
    send(atht_pkg::OP_ALLOC, pool[0], 32'd200);
    send(atht_pkg::OP_ALLOC, pool[16], 32'd300);
    send(atht_pkg::OP_ALLOC, pool[1], 32'd7);
    send(atht_pkg::OP_RELEASE, pool[0], 32'd0);
    send(atht_pkg::OP_RELEASE, pool[16], 32'd0);
    send(atht_pkg::OP_RELEASE, pool[0], 32'd0);
    send(atht_pkg::OP_RELEASE, pool[0], 32'd0);
    send(atht_pkg::OP_RELEASE, '1, 32'd0);
    send(atht_pkg::OP_RELEASE, 64'd1, 32'd0);
    send(atht_pkg::OP_CLEAR, '1, '1);
    send(atht_pkg::OP_RELEASE, 64'h8000_0000_0000_0000, 32'd0);
    send(atht_pkg::OP_ALLOC, 64'h5555_5555_5555_5555, 32'h5555_5555);
    send(atht_pkg::OP_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);

    // random phases with different sender gaps
    idle_pct = 0;
    random_burst(445);
    idle_pct = 68;
    random_burst(445);
    idle_pct = 0;
    random_burst(445);
    idle_pct = 20;
    random_burst(445);

    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
